// ===== src/isolated_spike_remover_top_defines.svh =====
// ----------------------------------------------------------------------
// Assertion macros for the isolated spike remover
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------
`ifndef ISOLATED_SPIKE_REMOVER_TOP_DEFINES_SVH
`define ISOLATED_SPIKE_REMOVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isr_pkg.sv =====
// ----------------------------------------------------------------------
// Isolated spike remover package
// Word types, register codes and reset values shared by the block.
// ----------------------------------------------------------------------
package isr_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int WLEN_BITS     = 6;
  localparam int THRESH_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPIKE_THRESHOLD = 2'd1;

  localparam logic [WLEN_BITS-1:0]   WLEN_RESET   = 6'd8;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd1311;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } isr_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in;
  } isr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          replaced;
    logic                          last_out;
  } isr_out_t;

  // Magnitude of a sample; the most negative value maps to 2**(SAMPLE_BITS-1).
  function automatic logic [SAMPLE_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] m;
    m = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
    return m;
  endfunction

endpackage

// ===== src/isolated_spike_remover_top.sv =====
// ----------------------------------------------------------------------
// Isolated spike remover: accepted words pass the stage 1 registers, then the output register.
// Throughput one word per cycle while the output is not stalled; the last
// word of a stream stalls the input until its flush of up to W words is done.
// Reset is synchronous; sums and counters clear, the delay line is not cleared.
// ----------------------------------------------------------------------
`include "isolated_spike_remover_top_defines.svh"

module isolated_spike_remover_top
  import isr_pkg::*;
#(
  parameter int MAX_WINDOW = 32
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  isr_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output isr_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int W_W   = $clog2(MAX_WINDOW + 1);
  localparam int AW    = $clog2(2 * MAX_WINDOW + 2);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int ACC_W = SUM_W + 1;

  // Configuration
  logic [WLEN_BITS-1:0]   wlen_r;
  logic [THRESH_BITS-1:0] thr_r;
  logic                   cfg_fire;

  // Input side
  logic                  in_fire;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         wp_r;
  logic [W_W-1:0]        aw_r;
  logic [SUM_W-1:0]      lim_r;
  logic [W_W-1:0]        w_clamp, w_cur;
  logic [AW-1:0]         w_ext, full_cnt, addr_a, addr_b;
  logic                  ge_w, ge_w1, ge_2w, ge_2w1;
  logic [W_W-1:0]        flen;

  // Stage 1
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [SAMPLE_BITS-1:0]        s1_mag_r;
  logic                          s1_last_r, s1_w1_r;
  logic                          s1_ge_w_r, s1_ge_w1_r, s1_ge_2w_r, s1_ge_2w1_r;
  logic [W_W-1:0]                s1_flen_r;
  logic [AW-1:0]                 s1_addr_r;

  // Neighbor history and running sums
  logic signed [SAMPLE_BITS-1:0] a1_r, a2_r;
  logic [SAMPLE_BITS-1:0]        a1_mag_r, a2_mag_r;
  logic [SUM_W-1:0]              rsum_r, lsum_r;

  logic signed [SAMPLE_BITS-1:0] rd_a_r, rd_b_r;
  logic signed [SAMPLE_BITS-1:0] nxt_smp;
  logic [SAMPLE_BITS-1:0]        nxt_mag, b_mag;
  logic [ACC_W-1:0]              rsum_acc, lsum_acc;
  logic [SUM_W-1:0]              rsum_new, lsum_new;
  logic [SAMPLE_BITS:0]          pair_sum;
  logic                          quiet_l, quiet_r, spike;
  isr_out_t                      center_word;

  // Control
  isr_state_t    state_r, state_nxt;
  logic          out_free, s1_adv, fl_send, fl_issue, out_load;
  logic          out_valid_r;
  isr_out_t      out_data_r;
  logic [W_W-1:0] fl_left_r;
  logic [AW-1:0] fl_addr_r;
  logic          fl_vld_r;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  assign cfg_ready = rst_n;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
      thr_r  <= THRESH_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN:      wlen_r <= cfg_data[WLEN_BITS-1:0];
        CFG_SPIKE_THRESHOLD: thr_r  <= cfg_data[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Input side: window latch, stream position and read addresses
  // ------------------------------------------------------------------
  always_comb begin
    if (wlen_r == '0) begin
      w_clamp = W_W'(1);
    end else if (wlen_r > WLEN_BITS'(MAX_WINDOW)) begin
      w_clamp = W_W'(MAX_WINDOW);
    end else begin
      w_clamp = W_W'(wlen_r);
    end
    w_cur    = (cnt_r == '0) ? w_clamp : aw_r;
    w_ext    = AW'(w_cur);
    full_cnt = (w_ext << 1) + AW'(1);
    ge_w     = cnt_r >= w_ext;
    ge_w1    = cnt_r >= (w_ext + AW'(1));
    ge_2w    = cnt_r >= (w_ext << 1);
    ge_2w1   = cnt_r >= full_cnt;
    // A short stream flushes everything it has, which is no more than W words.
    flen     = ge_w ? w_cur : W_W'(cnt_r + AW'(1));
    // Port A fetches the next center, the nearest right neighbor of the current one, port B
    // the sample that drops out of the left window.
    addr_a   = wp_r - w_ext + AW'(1);
    addr_b   = wp_r - full_cnt;
    if (in_data.last_in) begin
      cnt_nxt = '0;
    end else if (cnt_r < full_cnt) begin
      cnt_nxt = cnt_r + AW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (cnt_r == '0)) begin
      aw_r <= w_clamp;
    end
    lim_r <= SUM_W'(thr_r) * SUM_W'(aw_r);
  end

  isr_line_mem #(
    .ADDR_W (AW)
  ) u_line (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (wp_r),
    .wr_data   (in_data.sample_in),
    .rd_a_en   (in_fire || fl_issue),
    .rd_a_addr (fl_issue ? fl_addr_r : addr_a),
    .rd_a_r    (rd_a_r),
    .rd_b_en   (in_fire),
    .rd_b_addr (addr_b),
    .rd_b_r    (rd_b_r)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_data.sample_in;
      s1_mag_r    <= mag(in_data.sample_in);
      s1_last_r   <= in_data.last_in;
      s1_w1_r     <= (w_cur == W_W'(1));
      s1_ge_w_r   <= ge_w;
      s1_ge_w1_r  <= ge_w1;
      s1_ge_2w_r  <= ge_2w;
      s1_ge_2w1_r <= ge_2w1;
      s1_flen_r   <= flen;
      s1_addr_r   <= wp_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: running sums and spike decision
  // ------------------------------------------------------------------
  always_comb begin
    // With a one-sample window the right neighbor is the word just taken in.
    nxt_smp  = s1_w1_r ? s1_sample_r : rd_a_r;
    nxt_mag  = mag(nxt_smp);
    b_mag    = mag(rd_b_r);
    rsum_acc = ACC_W'(rsum_r) + ACC_W'(s1_mag_r)
             - (s1_ge_w_r ? ACC_W'(a1_mag_r) : ACC_W'(0));
    lsum_acc = ACC_W'(lsum_r) + (s1_ge_w1_r ? ACC_W'(a2_mag_r) : ACC_W'(0))
             - (s1_ge_2w1_r ? ACC_W'(b_mag) : ACC_W'(0));
    rsum_new = rsum_acc[SUM_W-1:0];
    lsum_new = lsum_acc[SUM_W-1:0];
    quiet_l  = {lsum_new, 1'b0} < {1'b0, lim_r};
    quiet_r  = {rsum_new, 1'b0} < {1'b0, lim_r};
    spike    = s1_ge_2w_r && (a1_mag_r >= thr_r) && quiet_l && quiet_r;
    pair_sum = {a2_r[SAMPLE_BITS-1], a2_r} + {nxt_smp[SAMPLE_BITS-1], nxt_smp};
    center_word.sample_out = spike ? pair_sum[SAMPLE_BITS:1] : a1_r;
    center_word.replaced   = spike;
    center_word.last_out   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      a1_r     <= nxt_smp;
      a1_mag_r <= nxt_mag;
      a2_r     <= a1_r;
      a2_mag_r <= a1_mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsum_r <= '0;
      lsum_r <= '0;
    end else if (s1_adv) begin
      rsum_r <= s1_last_r ? '0 : rsum_new;
      lsum_r <= s1_last_r ? '0 : lsum_new;
    end
  end

  // ------------------------------------------------------------------
  // Control: stream flow and end-of-stream flush
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (s1_adv && s1_last_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (fl_send && (fl_left_r == '0)) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_adv   = 1'b0;
    fl_send  = 1'b0;
    fl_issue = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        s1_adv = s1_valid_r && (!s1_ge_w_r || out_free);
      end
      ST_FLUSH: begin
        fl_send  = fl_vld_r && out_free;
        fl_issue = (fl_left_r != '0) && (!fl_vld_r || out_free);
      end
      default: ;
    endcase
    out_load = (s1_adv && s1_ge_w_r) || fl_send;
    // The last word of a stream holds the input until its flush is done.
    in_stall = !rst_n || (state_r != ST_RUN)
             || (s1_valid_r && (s1_last_r || !s1_adv));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fl_vld_r    <= 1'b0;
      fl_left_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv && s1_last_r) begin
        fl_left_r <= s1_flen_r;
        fl_vld_r  <= 1'b0;
      end else if (fl_issue) begin
        fl_left_r <= fl_left_r - W_W'(1);
        fl_vld_r  <= 1'b1;
      end else if (fl_send) begin
        fl_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      fl_addr_r <= s1_addr_r - AW'(s1_flen_r) + AW'(1);
    end else if (fl_issue) begin
      fl_addr_r <= fl_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fl_send) begin
      out_data_r.sample_out <= rd_a_r;
      out_data_r.replaced   <= 1'b0;
      out_data_r.last_out   <= (fl_left_r == '0);
    end else if (out_load) begin
      out_data_r <= center_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `ISR_ASSERT_NOW(a_flush_not_replaced, out_valid_r,
    !(out_data_r.replaced && out_data_r.last_out), "replaced word marked as last")
  `ISR_ASSERT_NEXT(a_last_starts_flush, s1_adv && s1_last_r,
    state_r == ST_FLUSH, "last word did not start a flush")
  `ISR_ASSERT_NEXT(a_sums_cleared, s1_adv && s1_last_r,
    (rsum_r == '0) && (lsum_r == '0), "sums not cleared at end of stream")
  `ISR_ASSERT_NEXT(a_flush_word_kept, (state_r == ST_FLUSH) && fl_vld_r && !out_free,
    fl_vld_r, "pending flush word lost while output stalled")

endmodule

// ===== src/isr_line_mem.sv =====
// ----------------------------------------------------------------------
// Sample delay line memory
// One write port and two read ports, read data registered on enable.
// ----------------------------------------------------------------------
module isr_line_mem
  import isr_pkg::*;
#(
  parameter int ADDR_W = 7
)
(
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic                          rd_a_en,
  input  logic [ADDR_W-1:0]             rd_a_addr,
  output logic signed [SAMPLE_BITS-1:0] rd_a_r,
  input  logic                          rd_b_en,
  input  logic [ADDR_W-1:0]             rd_b_addr,
  output logic signed [SAMPLE_BITS-1:0] rd_b_r
);

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

endmodule
